>>> hdl/timed_task_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// timed task priority queue assertion macros
// shared helpers for the concurrent checks on the queue ports
// ----------------------------------------------------------------------------
`ifndef TIMED_TASK_PRIORITY_QUEUE_MACROS_SVH
`define TIMED_TASK_PRIORITY_QUEUE_MACROS_SVH

// check sampled on the rising clock, masked while reset is low
`define TTPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check sampled on the rising clock, also active across reset
`define TTPQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/ttpq_pkg.sv
// ----------------------------------------------------------------------------
// ttpq_pkg
// types, constants and codes shared by the timed task priority queue
// ----------------------------------------------------------------------------
package ttpq_pkg;

    // field widths
    localparam int CodeW = 8;
    localparam int TickW = 64;

    // default store depth and results per tick request
    localparam int QueueDepth = 16;
    localparam int MaxResults = 16;
    localparam int CntW       = $clog2(MaxResults + 1);

    // depth of the command queue between front and back
    localparam int CmdQDepth = 2;

    // request op codes
    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DISPATCHED = 2'd0,
        ST_QUEUED     = 2'd1,
        ST_FULL       = 2'd2,
        ST_NONE       = 2'd3
    } t_status;

    // request kind decided by the front
    typedef enum logic [1:0] {
        KIND_NOW,
        KIND_ENQ,
        KIND_TICK
    } t_kind;

    // classified command; key is due tick for enqueue, counter for tick
    typedef struct packed {
        t_kind              kind;
        logic [CodeW-1:0]   code;
        logic [TickW-1:0]   key;
    } t_cmd;

    // one stored task
    typedef struct packed {
        logic [TickW-1:0]   due;
        logic [CodeW-1:0]   code;
    } t_entry;

    // store engine states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_START,
        S_INS_WALK,
        S_INS_PUT,
        S_DRAIN_CHK,
        S_DRAIN_RD,
        S_EMIT
    } t_back_state;

endpackage

>>> hdl/ttpq_ram.sv
// ----------------------------------------------------------------------------
// ttpq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ttpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ttpq_front.sv
// ----------------------------------------------------------------------------
// ttpq_front
// accepts requests and sorts them into already due, enqueue and tick commands
// ----------------------------------------------------------------------------
module ttpq_front
    import ttpq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_op,
    input  logic [CodeW-1:0] i_code,
    input  logic [TickW-1:0] i_due,
    input  logic [TickW-1:0] i_now,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // classify the request
    always_comb begin
        n_cmd.code = i_code;
        if (i_op == OP_TICK) begin
            n_cmd.kind = KIND_TICK;
            n_cmd.key  = i_now;
        end else if (i_due <= i_now) begin
            n_cmd.kind = KIND_NOW;
            n_cmd.key  = i_due;
        end else begin
            n_cmd.kind = KIND_ENQ;
            n_cmd.key  = i_due;
        end
    end

    // stage register moves on when the command queue takes it
    assign o_ready = !r_valid || i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

>>> hdl/ttpq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ttpq_cmd_fifo
// short command queue that decouples the front from the store engine
// ----------------------------------------------------------------------------
module ttpq_cmd_fifo
    import ttpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam int PtrW = $clog2(CmdQDepth);
    localparam int CntQW = $clog2(CmdQDepth + 1);
    localparam logic [PtrW-1:0]  LastIdx = PtrW'(CmdQDepth - 1);
    localparam logic [CntQW-1:0] FullCnt = CntQW'(CmdQDepth);

    t_cmd             r_mem [CmdQDepth];
    logic [PtrW-1:0]  r_wptr;
    logic [PtrW-1:0]  r_rptr;
    logic [CntQW-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != FullCnt);
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == LastIdx) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == LastIdx) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/ttpq_back.sv
// ----------------------------------------------------------------------------
// ttpq_back
// store engine: sorted insert by walking the ring, head drain, result register
// ----------------------------------------------------------------------------
module ttpq_back
    import ttpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [CodeW-1:0] o_code,
    output logic             o_armed,
    output logic [TickW-1:0] o_alarm,
    output logic             o_last
);

    localparam int PtrW  = $clog2(QUEUE_DEPTH);
    localparam int FillW = $clog2(QUEUE_DEPTH + 1);
    localparam int EntW  = $bits(t_entry);
    localparam logic [PtrW-1:0]  LastIdx = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [FillW-1:0] FullCnt = FillW'(QUEUE_DEPTH);
    localparam logic [CntW-1:0]  MaxCnt  = CntW'(MaxResults);

    // ring pointer steps
    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == LastIdx) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
        ptr_dec = (p == '0) ? LastIdx : p - 1'b1;
    endfunction

    t_back_state      r_state;
    t_back_state      n_state;

    // control registers
    logic [PtrW-1:0]  r_head;
    logic [PtrW-1:0]  n_head;
    logic [PtrW-1:0]  r_tail;
    logic [PtrW-1:0]  n_tail;
    logic [FillW-1:0] r_fill;
    logic [FillW-1:0] n_fill;
    logic             r_out_valid;
    logic             n_out_valid;

    // working registers
    logic [PtrW-1:0]  r_wp;
    logic [PtrW-1:0]  n_wp;
    logic [PtrW-1:0]  r_rp;
    logic [PtrW-1:0]  n_rp;
    logic [FillW-1:0] r_cnt;
    logic [FillW-1:0] n_cnt;
    logic [CntW-1:0]  r_n;
    logic [CntW-1:0]  n_n;
    logic [TickW-1:0] r_key;
    logic [TickW-1:0] n_key;
    logic [CodeW-1:0] r_code;
    logic [CodeW-1:0] n_code;
    t_entry           r_hd;
    t_entry           n_hd;
    t_status          r_res_status;
    t_status          n_res_status;
    logic [CodeW-1:0] r_res_code;
    logic [CodeW-1:0] n_res_code;
    logic             r_res_last;
    logic             n_res_last;

    // result register
    t_status          r_out_status;
    t_status          n_out_status;
    logic [CodeW-1:0] r_out_code;
    logic [CodeW-1:0] n_out_code;
    logic             r_out_armed;
    logic             n_out_armed;
    logic [TickW-1:0] r_out_alarm;
    logic [TickW-1:0] n_out_alarm;
    logic             r_out_last;
    logic             n_out_last;

    // store ram
    logic             ram_we;
    logic [PtrW-1:0]  ram_waddr;
    t_entry           ram_wdata;
    logic [PtrW-1:0]  ram_raddr;
    logic [EntW-1:0]  ram_rdata_raw;
    t_entry           ram_rdata;

    logic             out_free;
    logic             head_due;
    logic             walk_shift;
    logic             next_due;

    assign ram_rdata  = t_entry'(ram_rdata_raw);
    assign out_free   = !r_out_valid || i_ready;
    assign head_due   = (r_n < MaxCnt) && (r_fill != '0) && (r_hd.due <= r_key);
    assign walk_shift = (ram_rdata.due >= r_key);
    assign next_due   = (r_n < MaxCnt) && (r_fill != '0) && (ram_rdata.due <= r_key);

    ttpq_ram #(
        .WIDTH (EntW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EntW'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        KIND_NOW:  n_state = S_EMIT;
                        KIND_ENQ:  n_state = (r_fill == FullCnt) ? S_EMIT : S_INS_START;
                        KIND_TICK: n_state = S_DRAIN_CHK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_START: begin
                n_state = (r_fill == '0) ? S_INS_PUT : S_INS_WALK;
            end
            S_INS_WALK: begin
                if (!walk_shift || r_cnt == FillW'(1)) begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                n_state = S_EMIT;
            end
            S_DRAIN_CHK: begin
                n_state = head_due ? S_DRAIN_RD : S_EMIT;
            end
            S_DRAIN_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_res_last ? S_IDLE : S_DRAIN_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_cnt        = r_cnt;
        n_n          = r_n;
        n_key        = r_key;
        n_code       = r_code;
        n_hd         = r_hd;
        n_res_status = r_res_status;
        n_res_code   = r_res_code;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_code   = r_out_code;
        n_out_armed  = r_out_armed;
        n_out_alarm  = r_out_alarm;
        n_out_last   = r_out_last;
        o_cmd_ready  = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_wp;
        ram_wdata    = r_hd;
        ram_raddr    = ptr_dec(r_rp);

        // result leaves the register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_key      = i_cmd.key;
                    n_code     = i_cmd.code;
                    n_n        = '0;
                    n_res_code = i_cmd.code;
                    n_res_last = 1'b1;
                    case (i_cmd.kind)
                        KIND_NOW:  n_res_status = ST_DISPATCHED;
                        KIND_ENQ:  n_res_status = ST_FULL;
                        KIND_TICK: n_res_status = ST_NONE;
                        default:   n_res_status = ST_NONE;
                    endcase
                end
            end
            // start the walk from the tail toward the head
            S_INS_START: begin
                n_wp      = r_tail;
                n_rp      = ptr_dec(r_tail);
                n_cnt     = r_fill;
                ram_raddr = ptr_dec(r_tail);
            end
            // move one entry up while it is not earlier than the new one
            S_INS_WALK: begin
                if (walk_shift) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wp;
                    ram_wdata = ram_rdata;
                    n_wp      = r_rp;
                    n_rp      = ptr_dec(r_rp);
                    n_cnt     = r_cnt - 1'b1;
                end
            end
            // place the new entry in the gap
            S_INS_PUT: begin
                ram_we         = 1'b1;
                ram_waddr      = r_wp;
                ram_wdata.due  = r_key;
                ram_wdata.code = r_code;
                if (r_wp == r_head) begin
                    n_hd.due  = r_key;
                    n_hd.code = r_code;
                end
                n_tail       = ptr_inc(r_tail);
                n_fill       = r_fill + 1'b1;
                n_res_status = ST_QUEUED;
                n_res_code   = r_code;
                n_res_last   = 1'b1;
            end
            // pop the head if due and fetch its successor
            S_DRAIN_CHK: begin
                ram_raddr = ptr_inc(r_head);
                if (head_due) begin
                    n_res_status = ST_DISPATCHED;
                    n_res_code   = r_hd.code;
                    n_head       = ptr_inc(r_head);
                    n_fill       = r_fill - 1'b1;
                    n_n          = r_n + 1'b1;
                end else begin
                    n_res_status = ST_NONE;
                    n_res_code   = '0;
                    n_res_last   = 1'b1;
                end
            end
            // new head lands in the cache
            S_DRAIN_RD: begin
                n_hd       = ram_rdata;
                n_res_last = !next_due;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_code   = r_res_code;
                    n_out_armed  = (r_fill != '0);
                    n_out_alarm  = (r_fill != '0) ? r_hd.due : '0;
                    n_out_last   = r_res_last;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_wp         <= n_wp;
        r_rp         <= n_rp;
        r_cnt        <= n_cnt;
        r_n          <= n_n;
        r_key        <= n_key;
        r_code       <= n_code;
        r_hd         <= n_hd;
        r_res_status <= n_res_status;
        r_res_code   <= n_res_code;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_code   <= n_out_code;
        r_out_armed  <= n_out_armed;
        r_out_alarm  <= n_out_alarm;
        r_out_last   <= n_out_last;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_code   = r_out_code;
    assign o_armed  = r_out_armed;
    assign o_alarm  = r_out_alarm;
    assign o_last   = r_out_last;

endmodule

>>> hdl/timed_task_priority_queue.sv
// Flow: an already due or rejected enqueue goes through the front stage, the command
//   queue and the store engine to the result register; a queued enqueue first walks the
//   ring from the tail, moving up one place each stored entry not earlier than it.
// Throughput: one request at a time in the store engine, whose one-entry-per-cycle ring
//   walk sets the pace of an enqueue; a tick emits its dispatched entries one by one.
// Reset: synchronous active low; empties the store and all queues, store contents
//   stay as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// timed_task_priority_queue
// task store sorted by due tick with immediate dispatch and tick driven drain
// ----------------------------------------------------------------------------
module timed_task_priority_queue
    import ttpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // task_code[7:0], due_tick[71:8], now_tick[135:72]
    input  logic [0:0]   s_axis_tuser,  // op[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,  // out_code[7:0], alarm_armed[8], alarm_tick[72:9]
    output logic [1:0]   m_axis_tuser,  // status[1:0]
    output logic         m_axis_tlast
);

    logic             front_valid;
    t_cmd             front_cmd;
    logic             fifo_ready;
    logic             fifo_valid;
    t_cmd             fifo_cmd;
    logic             back_ready;
    logic [CodeW-1:0] out_code;
    logic             out_armed;
    logic [TickW-1:0] out_alarm;

    // request intake and classification
    ttpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser[0]),
        .i_code      (s_axis_tdata[7:0]),
        .i_due       (s_axis_tdata[71:8]),
        .i_now       (s_axis_tdata[135:72]),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (fifo_ready)
    );

    // command queue
    ttpq_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (fifo_ready),
        .i_cmd   (front_cmd),
        .o_valid (fifo_valid),
        .i_ready (back_ready),
        .o_cmd   (fifo_cmd)
    );

    // store engine
    ttpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (fifo_valid),
        .i_cmd       (fifo_cmd),
        .o_cmd_ready (back_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_code      (out_code),
        .o_armed     (out_armed),
        .o_alarm     (out_alarm),
        .o_last      (m_axis_tlast)
    );

    // result packing
    assign m_axis_tdata = {7'd0, out_alarm, out_armed, out_code};

endmodule

>>> hdl/ttpq_checker.sv
// ----------------------------------------------------------------------------
// ttpq_checker
// port level checks on the result stream of the timed task priority queue
// ----------------------------------------------------------------------------
`include "timed_task_priority_queue_macros.svh"

module ttpq_checker
    import ttpq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result stays offered
    `TTPQ_ASSERT(a_valid_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result valid dropped while stalled")

    // a stalled result keeps its payload
    `TTPQ_ASSERT(a_data_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

    // an empty store reports no alarm tick
    `TTPQ_ASSERT(a_alarm_empty, m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[72:9] == 64'd0, "alarm tick set with empty store")

    // only drained entries can be followed by more results
    `TTPQ_ASSERT(a_single_last, m_axis_tvalid && m_axis_tuser != ST_DISPATCHED |-> m_axis_tlast, "non-dispatch result not marked last")

    // nothing offered right after reset
    `TTPQ_ASSERT_RST(a_reset_idle, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind timed_task_priority_queue ttpq_checker u_ttpq_checker (.*);

>>> tb/timed_task_priority_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_task_priority_queue_test
// drives enqueue and tick requests into the sorted task queue, keeps a
// shadow copy of the due-ordered store and checks every result in order
// ----------------------------------------------------------------------------
module timed_task_priority_queue_test;
    import ttpq_pkg::*;

    localparam int Depth          = QueueDepth;
    localparam int LongHoldCycles = 300;
    localparam int MaxPrinted     = 40;

    // one predicted result beat
    typedef struct packed {
        t_status            status;
        logic [CodeW-1:0]   code;
        logic               armed;
        logic [TickW-1:0]   alarm;
        logic               last;
    } t_report;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // task_code[7:0], due_tick[71:8], now_tick[135:72]
    logic [0:0]   s_axis_tuser;   // op[0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;   // out_code[7:0], alarm_armed[8], alarm_tick[72:9]
    logic [1:0]   m_axis_tuser;   // status[1:0]
    logic         m_axis_tlast;

    // shadow of the due-ordered store
    logic [TickW-1:0] shadow_due [Depth];
    logic [CodeW-1:0] shadow_code[Depth];
    int               shadow_fill = 0;

    t_report awaited_reports[$];

    int error_count    = 0;
    int enq_requests   = 0;
    int tick_requests  = 0;
    int seen_dispatch  = 0;
    int seen_queued    = 0;
    int seen_full      = 0;
    int seen_none      = 0;
    int longest_drain  = 0;

    // sender pacing
    int burst_left   = 0;
    bit gaps_enabled = 1'b1;

    // receiver controls
    bit long_hold_pending = 1'b0;
    bit drain_ready       = 1'b0;

    timed_task_priority_queue #(
        .QUEUE_DEPTH(Depth)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue one result using the shadow head after the update
    function automatic void push_report(input t_status status, input logic [CodeW-1:0] code,
                                        input logic last);
        t_report r;
        r.status = status;
        r.code   = code;
        r.armed  = (shadow_fill > 0);
        r.alarm  = (shadow_fill > 0) ? shadow_due[0] : '0;
        r.last   = last;
        awaited_reports.push_back(r);
    endfunction

    // apply one accepted request to the shadow store and queue its results
    function automatic void update_task_store(input logic op, input logic [CodeW-1:0] code,
                                              input logic [TickW-1:0] due,
                                              input logic [TickW-1:0] now);
        int pos;
        int i;
        int n;
        logic [CodeW-1:0] head_code;
        logic done;
        if (op == OP_ENQ) begin
            enq_requests++;
            if (due <= now) begin
                push_report(ST_DISPATCHED, code, 1'b1);
            end else if (shadow_fill >= Depth) begin
                push_report(ST_FULL, code, 1'b1);
            end else begin
                // new entry lands ahead of equal due ticks
                pos = 0;
                while (pos < shadow_fill && shadow_due[pos] < due) pos++;
                for (i = shadow_fill; i > pos; i--) begin
                    shadow_due[i]  = shadow_due[i-1];
                    shadow_code[i] = shadow_code[i-1];
                end
                shadow_due[pos]  = due;
                shadow_code[pos] = code;
                shadow_fill++;
                push_report(ST_QUEUED, code, 1'b1);
            end
        end else begin
            tick_requests++;
            n = 0;
            done = 1'b0;
            while (!done && n < MaxResults && shadow_fill > 0 && shadow_due[0] <= now) begin
                head_code = shadow_code[0];
                for (i = 0; i < shadow_fill - 1; i++) begin
                    shadow_due[i]  = shadow_due[i+1];
                    shadow_code[i] = shadow_code[i+1];
                end
                shadow_fill--;
                n++;
                done = (n == MaxResults) || (shadow_fill == 0) || (shadow_due[0] > now);
                push_report(ST_DISPATCHED, head_code, done);
            end
            if (n == 0) push_report(ST_NONE, '0, 1'b1);
            if (n > longest_drain) longest_drain = n;
        end
    endfunction

    // offer one request and hold it until taken, then maybe pause
    task automatic send_request(input logic op, input logic [CodeW-1:0] code,
                                input logic [TickW-1:0] due, input logic [TickW-1:0] now);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, due, code};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        update_task_store(op, code, due, now);
        if (burst_left > 0) burst_left--;
        if (gaps_enabled && burst_left == 0) begin
            gap = $urandom_range(1, 24);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(1, 8);
        end
    endtask

    // receiver: phased stall pattern plus an optional long hold
    initial begin
        int phase;
        int hold_left;
        logic rdy;
        phase = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left = LongHoldCycles;
            end
            if (drain_ready) begin
                rdy = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case ((phase / 97) % 3)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 99) < 60);
                    default: rdy = (phase % 4 == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_report r;
        logic bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_reports.size() == 0) begin
                error_count++;
                if (error_count <= MaxPrinted)
                    $display("%0t: result expected none actual status=%0d code=%0h tick=%0h",
                             $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[72:9]);
            end else begin
                r = awaited_reports.pop_front();
                bad = 1'b0;
                if (m_axis_tuser !== r.status) begin
                    bad = 1'b1;
                    if (error_count < MaxPrinted)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, r.status, m_axis_tuser);
                end
                if (m_axis_tdata[7:0] !== r.code) begin
                    bad = 1'b1;
                    if (error_count < MaxPrinted)
                        $display("%0t: out_code expected %0h actual %0h",
                                 $time, r.code, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[8] !== r.armed) begin
                    bad = 1'b1;
                    if (error_count < MaxPrinted)
                        $display("%0t: alarm_armed expected %0b actual %0b",
                                 $time, r.armed, m_axis_tdata[8]);
                end
                if (m_axis_tdata[72:9] !== r.alarm) begin
                    bad = 1'b1;
                    if (error_count < MaxPrinted)
                        $display("%0t: alarm_tick expected %0h actual %0h",
                                 $time, r.alarm, m_axis_tdata[72:9]);
                end
                if (m_axis_tlast !== r.last) begin
                    bad = 1'b1;
                    if (error_count < MaxPrinted)
                        $display("%0t: last expected %0b actual %0b",
                                 $time, r.last, m_axis_tlast);
                end
                if (m_axis_tdata[79:73] !== '0) begin
                    bad = 1'b1;
                    if (error_count < MaxPrinted)
                        $display("%0t: tdata pad expected 0 actual %0h",
                                 $time, m_axis_tdata[79:73]);
                end
                if (bad) error_count++;
                case (r.status)
                    ST_DISPATCHED: seen_dispatch++;
                    ST_QUEUED:     seen_queued++;
                    ST_FULL:       seen_full++;
                    default:       seen_none++;
                endcase
            end
        end
    end

    // empty store, extreme ticks, due equal to now
    task automatic test_empty_and_extremes();
        send_request(OP_TICK, 8'h00, '0, '0);
        send_request(OP_ENQ, 8'hFF, '1, '0);
        send_request(OP_ENQ, 8'h00, '0, '0);
        send_request(OP_ENQ, 8'hA5, 64'd5, '1);
        send_request(OP_TICK, 8'h3C, '1, '1 - 64'd1);
    endtask

    // equal due ticks and insertion at the head
    task automatic test_equal_due_order();
        send_request(OP_ENQ, 8'h01, 64'd100, 64'd10);
        send_request(OP_ENQ, 8'h02, 64'd100, 64'd10);
        send_request(OP_ENQ, 8'h03, 64'd50, 64'd10);
    endtask

    // fill the store, then a rejection and a due task while full
    task automatic test_full_store();
        int i;
        for (i = 0; i < Depth - 4; i++)
            send_request(OP_ENQ, 8'($urandom_range(0, 255)), 64'd200 + 64'(i), 64'd10);
        send_request(OP_ENQ, 8'hEE, 64'd300, 64'd10);
        send_request(OP_ENQ, 8'h77, 64'd7, 64'd10);
    endtask

    // a single tick drains the whole store, then finds nothing
    task automatic test_drain_limit();
        send_request(OP_TICK, 8'h55, '0, '1);
        send_request(OP_TICK, 8'hAA, '1, '1);
    endtask

    // mostly a coherent timeline with random content, plus noise
    task automatic test_random_traffic(input int n_items);
        logic [TickW-1:0] clock_now;
        logic [TickW-1:0] recent_due;
        logic [TickW-1:0] due;
        logic [TickW-1:0] now;
        logic [CodeW-1:0] code;
        logic op;
        int pick;
        clock_now = {$urandom, $urandom};
        recent_due = clock_now;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            code = 8'($urandom_range(0, 255));
            due  = {$urandom, $urandom};
            op   = OP_ENQ;
            if (pick < 4) begin
                // jump the timeline, sometimes close to the counter wrap
                clock_now = $urandom_range(0, 1) ? {$urandom, $urandom}
                                                 : '1 - 64'($urandom_range(0, 30));
                op = OP_TICK;
            end else if (pick < 50) begin
                if ($urandom_range(0, 4) == 0 && recent_due > clock_now)
                    due = recent_due;
                else
                    due = clock_now + 64'($urandom_range(1, 60));
                recent_due = due;
            end else if (pick < 75) begin
                clock_now = clock_now + 64'($urandom_range(0, 40));
                op = OP_TICK;
            end else if (pick < 85) begin
                due = clock_now - 64'($urandom_range(0, 20));
            end else begin
                op = 1'($urandom_range(0, 1));
                clock_now = {$urandom, $urandom};
            end
            now = clock_now;
            send_request(op, code, due, now);
        end
    endtask

    // receiver holds off while requests keep coming back to back
    task automatic test_output_backpressure(input int n_items);
        logic [TickW-1:0] now;
        gaps_enabled = 1'b0;
        long_hold_pending = 1'b1;
        now = {$urandom, $urandom};
        repeat (n_items) begin
            now = now + 64'($urandom_range(0, 8));
            case ($urandom_range(0, 2))
                0: send_request(OP_ENQ, 8'($urandom_range(0, 255)),
                                now - 64'($urandom_range(0, 5)), now);
                1: send_request(OP_ENQ, 8'($urandom_range(0, 255)),
                                now + 64'($urandom_range(1, 20)), now);
                default: send_request(OP_TICK, 8'($urandom_range(0, 255)),
                                      {$urandom, $urandom}, now);
            endcase
        end
        gaps_enabled = 1'b1;
    endtask

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_extremes();
        test_equal_due_order();
        test_full_store();
        test_drain_limit();
        test_random_traffic(80);
        test_output_backpressure(40);
        test_random_traffic(40);

        s_axis_tvalid <= 1'b0;
        drain_ready = 1'b1;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("covered %0d enqueue and %0d tick requests, longest drain %0d entries",
                 enq_requests, tick_requests, longest_drain);
        $display("results: %0d dispatched, %0d queued, %0d rejected full, %0d nothing due",
                 seen_dispatch, seen_queued, seen_full, seen_none);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ttpq_pkg.sv
hdl/ttpq_ram.sv
hdl/ttpq_front.sv
hdl/ttpq_cmd_fifo.sv
hdl/ttpq_back.sv
hdl/timed_task_priority_queue.sv
hdl/ttpq_checker.sv
tb/timed_task_priority_queue_test.sv
